/* design/frame_bitmap_allocator_top_macros.svh */
// ----------------------------------------------------------------------------
// Frame bitmap allocator assertion macros
// Shared assertion forms, clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef FRAME_BITMAP_ALLOCATOR_TOP_MACROS_SVH
`define FRAME_BITMAP_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication.
`define FBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FBA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/fba_pkg.sv */
// ----------------------------------------------------------------------------
// Frame bitmap allocator package
// Field widths, request kinds, queue entry and sequencer state types.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int KIND_W         = 2;
  localparam int IDX_W          = 12;
  localparam int CNT_W          = 13;
  localparam int WORD_BITS      = 64;
  localparam int BIT_W          = 6;
  localparam int DEF_MAX_FRAMES = 4096;
  localparam int QUEUE_DEPTH    = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_MARK_USED = 2'd0,
    KIND_MARK_FREE = 2'd1,
    KIND_TEST      = 2'd2,
    KIND_FIND      = 2'd3
  } kind_t;

  // Classified request as it travels from the front to the back.
  typedef struct packed {
    kind_t              kind;
    logic [IDX_W-1:0]   idx;
    logic [CNT_W-1:0]   limit;
    logic               oor;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_SCAN
  } st_t;

  // Position of the lowest clear bit of a bitmap word.
  function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

/* design/fba_req_if.sv */
// ----------------------------------------------------------------------------
// Frame bitmap allocator request channel
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
interface fba_req_if import fba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0]  frame_index;

  modport source (output valid, kind, frame_index, input ready);
  modport sink   (input valid, kind, frame_index, output ready);
endinterface

/* design/fba_rsp_if.sv */
// ----------------------------------------------------------------------------
// Frame bitmap allocator response channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface fba_rsp_if import fba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             frame_used;
  logic             found;
  logic [IDX_W-1:0] free_index;
  logic             out_of_range;

  modport source (output valid, frame_used, found, free_index, out_of_range, input ready);
  modport sink   (input valid, frame_used, found, free_index, out_of_range, output ready);
endinterface

/* design/fba_front.sv */
// ----------------------------------------------------------------------------
// Frame bitmap allocator front end
// Holds the frame count register, accepts requests and checks their range.
// ----------------------------------------------------------------------------
module fba_front import fba_pkg::*; #(
  parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  fba_req_if.sink          req,
  input  logic             busy,
  input  logic             q_full,
  output logic             push,
  output cmd_t             push_data
);

  logic [CNT_W-1:0] frame_count;
  logic [CNT_W-1:0] limit;
  kind_t            kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
    end else if (cfg_wr_en) begin
      frame_count <= cfg_wr_data;
    end
  end

  // The usable range is the configured count, saturated at MAX_FRAMES.
  always_comb begin
    if (32'(frame_count) > 32'(MAX_FRAMES)) begin
      limit = CNT_W'(MAX_FRAMES);
    end else begin
      limit = frame_count;
    end
  end

  assign kind      = kind_t'(req.kind);
  assign req.ready = !q_full && !busy;
  assign push      = req.valid && req.ready;

  always_comb begin
    push_data.kind  = kind;
    push_data.idx   = req.frame_index;
    push_data.limit = limit;
    push_data.oor   = (kind != KIND_FIND) && (CNT_W'(req.frame_index) >= limit);
  end

endmodule

/* design/fba_queue.sv */
// ----------------------------------------------------------------------------
// Frame bitmap allocator command queue
// Short FIFO between the front end and the bitmap sequencer.
// ----------------------------------------------------------------------------
module fba_queue import fba_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  cmd_t              entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] count;

  assign full  = (count == CNT_QW'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* design/fba_back.sv */
// ----------------------------------------------------------------------------
// Frame bitmap allocator back end
// Bitmap memory, clearing pass, mark/test access, free frame scan and the
// result register.
// ----------------------------------------------------------------------------
`include "frame_bitmap_allocator_top_macros.svh"

module fba_back import fba_pkg::*; #(
  parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_empty,
  input  cmd_t    head,
  output logic    pop,
  output logic    busy,
  fba_rsp_if.source rsp
);

  localparam int MAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;

  st_t                  state;
  st_t                  state_next;
  logic [AW-1:0]        clr;
  logic [AW-1:0]        chk;
  cmd_t                 cmd;

  logic                 out_valid;
  logic                 out_used;
  logic                 out_found;
  logic [IDX_W-1:0]     out_index;
  logic                 out_oor;

  logic                 load;
  logic                 res_used;
  logic                 res_found;
  logic [IDX_W-1:0]     res_index;
  logic                 res_oor;
  logic                 scan_done;

  logic [31:0]          head_word;
  logic [31:0]          cmd_word;
  logic [BIT_W-1:0]     bit_pos;
  logic [WORD_BITS-1:0] bit_mask;
  logic [BIT_W-1:0]     zpos;
  logic [31:0]          cand;
  logic [31:0]          next_base;

  // Bitmap storage, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  assign head_word = 32'(head.idx) >> BIT_W;
  assign cmd_word  = 32'(cmd.idx) >> BIT_W;
  assign bit_pos   = cmd.idx[BIT_W-1:0];
  assign bit_mask  = WORD_BITS'(1) << bit_pos;
  assign zpos      = lowest_zero(rdata);
  assign cand      = (32'(chk) << BIT_W) | 32'(zpos);
  assign next_base = (32'(chk) + 32'd1) << BIT_W;

  // The scan stops at the first word with a clear bit, at the last word, or
  // once the next word would lie wholly beyond the frame limit.
  assign scan_done = !(&rdata) || (chk == LAST_WORD) || (next_base >= 32'(cmd.limit));

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr == LAST_WORD) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop && !head.oor) begin
          state_next = (head.kind == KIND_FIND) ? ST_SCAN : ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    busy      = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = clr;
    mem_wdata = '0;
    mem_raddr = '0;
    load      = 1'b0;
    res_used  = 1'b0;
    res_found = 1'b0;
    res_index = '0;
    res_oor   = 1'b0;
    case (state)
      ST_CLEAR: begin
        busy   = 1'b1;
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        pop = !q_empty && !out_valid;
        if (head.kind != KIND_FIND) begin
          mem_raddr = head_word[AW-1:0];
        end
        if (pop && head.oor) begin
          load    = 1'b1;
          res_oor = 1'b1;
        end
      end
      ST_ACCESS: begin
        load      = 1'b1;
        mem_waddr = cmd_word[AW-1:0];
        case (cmd.kind)
          KIND_MARK_USED: begin
            mem_we    = 1'b1;
            mem_wdata = rdata | bit_mask;
          end
          KIND_MARK_FREE: begin
            mem_we    = 1'b1;
            mem_wdata = rdata & ~bit_mask;
          end
          KIND_TEST: begin
            res_used = |(rdata & bit_mask);
          end
          default: begin
            res_used = 1'b0;
          end
        endcase
      end
      ST_SCAN: begin
        mem_raddr = chk + 1'b1;
        if (scan_done) begin
          load = 1'b1;
          if (!(&rdata) && (cand < 32'(cmd.limit))) begin
            res_found = 1'b1;
            res_index = cand[IDX_W-1:0];
          end
        end
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr <= clr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head;
    end
    if (state == ST_IDLE) begin
      chk <= '0;
    end else if (state == ST_SCAN) begin
      chk <= chk + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_used  <= res_used;
      out_found <= res_found;
      out_index <= res_index;
      out_oor   <= res_oor;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.frame_used   = out_used;
  assign rsp.found        = out_found;
  assign rsp.free_index   = out_index;
  assign rsp.out_of_range = out_oor;

  `FBA_ASSERT_IMP(a_load_empty, load, !out_valid, "result loaded over a waiting word")
  `FBA_ASSERT_IMP(a_found_oor, out_valid, !(out_found && out_oor), "found and out of range together")
  `FBA_ASSERT_NXT(a_clear_end, (state == ST_CLEAR) && (clr == LAST_WORD), state == ST_IDLE,
                  "clearing pass did not end")
  `FBA_ASSERT_IMP(a_found_limit, load && res_found, cand < 32'(cmd.limit),
                  "free frame beyond limit")

endmodule

/* design/frame_bitmap_allocator_top.sv */
// ----------------------------------------------------------------------------
// Frame bitmap allocator
// Used/free bitmap of physical frames with mark, free, test and find-free.
// ----------------------------------------------------------------------------
// Requests enter on req (kind, frame_index) and each yields exactly one word on
// rsp (frame_used, found, free_index, out_of_range), in request order.
// frame_count is written through cfg_wr_en/cfg_wr_data only while the block is
// idle; it is the user who must keep to this, as the block has no check for it.
// After reset the bitmap memory is cleared one word per cycle, MAX_FRAMES/64
// words rounded up; req.ready stays low for that time. An out-of-range mark
// or test is answered without a bitmap access, an in-range mark or test with
// one read and, for a mark, one write-back of a bitmap word. A find reads one
// bitmap word per cycle from word 0 until the first word with a clear bit, the
// last word or the frame limit. The back end works on one request at a time;
// a two-entry queue lets the front keep accepting while a result waits in the
// output register. When the receiver stalls, the result is held and the back
// end takes no new request.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_top import fba_pkg::*; #(
  parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  fba_req_if.sink          req,
  fba_rsp_if.source        rsp
);

  logic busy;
  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  cmd_t push_data;
  cmd_t head;

  fba_front #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req),
    .busy       (busy),
    .q_full     (q_full),
    .push       (push),
    .push_data  (push_data)
  );

  fba_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  fba_back #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_empty(q_empty),
    .head   (head),
    .pop    (pop),
    .busy   (busy),
    .rsp    (rsp)
  );

endmodule
